// File: hdl/pcpg_pkg.sv
// shared types, constants and functions for the polar circle point generator
package pcpg_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW = $clog2(CordicSteps + 1);
  localparam logic [23:0] AngleFinal = 24'd51470;
  localparam logic [30:0] GainQ30 = 31'd652032874;
  localparam logic [23:0] AngleMax = 24'hFFFFFF;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_e;

  // command from front to back
  typedef struct packed {
    logic               is_bad;
    logic               is_start;
    logic [15:0]        radius;
    logic [23:0]        angle;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic               done;
  } cmd_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      default: v = 32'd1 << (5'd30 - idx);
    endcase
    return v;
  endfunction

endpackage

// File: hdl/pcpg_front.sv
// front end: accepts items, divides for the angle increment, tracks the angle
module pcpg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic                req_type_i,
  input  logic [15:0]         radius_i,
  input  logic signed [15:0]  center_x_i,
  input  logic signed [15:0]  center_y_i,
  output logic                cmd_valid_o,
  input  logic                cmd_stall_i,
  output pcpg_pkg::cmd_t      cmd_o
);
  import pcpg_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SEND} state_e;

  state_e             state_q;
  logic               active_q;
  logic [23:0]        angle_q, step_q;
  logic [15:0]        radius_q;
  logic signed [15:0] cx_q, cy_q;
  logic [24:0]        quot_q;
  logic [16:0]        rem_q;
  logic [4:0]         cnt_q;
  cmd_t               cmd_q;
  logic [17:0]        rem_sh;
  logic [24:0]        na;

  assign stall_o     = (state_q != S_IDLE);
  assign cmd_valid_o = (state_q == S_SEND);
  assign cmd_o       = cmd_q;
  // restoring division of 2^24 by radius, one bit a cycle
  assign rem_sh = {rem_q, (cnt_q == 5'd24)};
  assign na     = {1'b0, angle_q} + {1'b0, step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= 1'b0;
      angle_q  <= '0;
      step_q   <= '0;
      radius_q <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      quot_q   <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      cmd_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            if (req_type_i == REQ_START) begin
              if (radius_i == 16'd0) begin
                active_q <= 1'b0;
                cmd_q    <= '{is_bad: 1'b1, is_start: 1'b1, radius: '0, angle: '0,
                              cx: '0, cy: '0, done: 1'b0};
                state_q  <= S_SEND;
              end else begin
                radius_q <= radius_i;
                cx_q     <= center_x_i;
                cy_q     <= center_y_i;
                quot_q   <= '0;
                rem_q    <= '0;
                cnt_q    <= 5'd24;
                angle_q  <= '0;
                active_q <= 1'b1;
                cmd_q    <= '{is_bad: 1'b0, is_start: 1'b1, radius: radius_i, angle: '0,
                              cx: center_x_i, cy: center_y_i, done: 1'b0};
                state_q  <= S_DIV;
              end
            end else if (!active_q || angle_q >= AngleFinal) begin
              active_q <= 1'b0;
            end else begin
              angle_q  <= na[24] ? AngleMax : na[23:0];
              active_q <= !(na[24] || na[23:0] >= AngleFinal);
              cmd_q    <= '{is_bad: 1'b0, is_start: 1'b0, radius: radius_q,
                            angle: angle_q, cx: cx_q, cy: cy_q,
                            done: (na[24] || na[23:0] >= AngleFinal)};
              state_q  <= S_SEND;
            end
          end
        end
        S_DIV: begin
          if (rem_sh >= {2'b0, radius_q}) begin
            rem_q  <= 17'(rem_sh - {2'b0, radius_q});
            quot_q <= {quot_q[23:0], 1'b1};
          end else begin
            rem_q  <= rem_sh[16:0];
            quot_q <= {quot_q[23:0], 1'b0};
          end
          if (cnt_q == 5'd0) begin
            state_q <= S_SEND;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        S_SEND: begin
          if (quot_q[24] && cmd_q.is_start && !cmd_q.is_bad) begin
            step_q <= AngleMax;
          end else if (cmd_q.is_start && !cmd_q.is_bad) begin
            step_q <= quot_q[23:0];
          end
          if (!cmd_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/pcpg_queue.sv
// two-entry queue between front and back
module pcpg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pcpg_pkg::cmd_t in_cmd_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pcpg_pkg::cmd_t out_cmd_o
);
  import pcpg_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_cmd_o   = mem_q[rd_q];
  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end
endmodule

// File: hdl/pcpg_back.sv
// back end: cordic rotation, eight-way point emission and the bad-radius result
module pcpg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_stall_o,
  input  pcpg_pkg::cmd_t      cmd_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic signed [17:0]  point_x_o,
  output logic signed [17:0]  point_y_o,
  output logic [2:0]          octant_o,
  output logic                last_of_step_o,
  output logic                circle_done_o,
  output logic                bad_radius_o
);
  import pcpg_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_GAIN, S_ROT, S_EMIT} state_e;

  state_e             state_q;
  logic signed [40:0] x_q, y_q, z_q;
  logic [StepW-1:0]   it_q;
  logic [2:0]         k_q;
  logic               done_q, bad_q;
  logic signed [15:0] cx_q, cy_q;
  logic signed [17:0] ox, oy, ax, ay;
  logic signed [40:0] dx, dy, at, xr, yr;
  logic [46:0]        prod;
  logic               emit_load;
  logic               unused;

  assign cmd_stall_o = (state_q != S_IDLE);
  assign prod = {16'd0, cmd_i.radius} * {16'd0, GainQ30};
  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign at = 41'($signed({1'b0, atan_q30(5'(it_q))}));
  assign xr = (x_q + 41'sd8192) >>> 14;
  assign yr = (y_q + 41'sd8192) >>> 14;
  assign ax = xr[17:0];
  assign ay = yr[17:0];
  assign emit_load = (state_q == S_EMIT) && (!valid_o || !stall_i);
  assign unused = ^prod[15:0];

  always_comb begin
    case (k_q)
      3'd0: begin ox = ax;  oy = ay;  end
      3'd1: begin ox = -ax; oy = ay;  end
      3'd2: begin ox = -ax; oy = -ay; end
      3'd3: begin ox = ax;  oy = -ay; end
      3'd4: begin ox = ay;  oy = ax;  end
      3'd5: begin ox = -ay; oy = ax;  end
      3'd6: begin ox = -ay; oy = -ax; end
      default: begin ox = ay; oy = -ax; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_o <= 1'b0;
      it_q    <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
      bad_q   <= 1'b0;
      cx_q    <= '0;
      cy_q    <= '0;
      x_q <= '0; y_q <= '0; z_q <= '0;
      point_x_o <= '0; point_y_o <= '0; octant_o <= '0;
      last_of_step_o <= 1'b0; circle_done_o <= 1'b0; bad_radius_o <= 1'b0;
    end else begin
      if (emit_load) begin
        valid_o <= 1'b1;
      end else if (!stall_i) begin
        valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            done_q <= cmd_i.done;
            bad_q  <= cmd_i.is_bad;
            cx_q   <= cmd_i.cx;
            cy_q   <= cmd_i.cy;
            k_q    <= '0;
            if (cmd_i.is_bad) begin
              state_q <= S_EMIT;
            end else if (cmd_i.is_start) begin
              // offsets already in q14 so rounding returns the radius
              x_q <= 41'($signed({1'b0, cmd_i.radius, 14'd0}));
              y_q <= '0;
              state_q <= S_EMIT;
            end else begin
              x_q  <= 41'($signed({1'b0, prod[46:16]}));
              y_q  <= '0;
              z_q  <= 41'($signed({1'b0, cmd_i.angle, 14'd0}));
              it_q <= '0;
              state_q <= S_ROT;
            end
          end
        end
        S_ROT: begin
          if (!z_q[40]) begin
            x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
          end else begin
            x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
          end
          if (it_q == StepW'(CordicSteps - 1)) begin
            state_q <= S_EMIT;
          end
          it_q <= it_q + StepW'(1);
        end
        S_EMIT: begin
          if (emit_load) begin
            bad_radius_o <= bad_q;
            if (bad_q) begin
              point_x_o <= '0; point_y_o <= '0; octant_o <= '0;
              last_of_step_o <= 1'b0; circle_done_o <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              point_x_o      <= 18'({{2{cx_q[15]}}, cx_q}) + ox;
              point_y_o      <= 18'({{2{cy_q[15]}}, cy_q}) + oy;
              octant_o       <= k_q;
              last_of_step_o <= (k_q == 3'd7);
              circle_done_o  <= (k_q == 3'd7) && done_q;
              k_q <= k_q + 3'd1;
              if (k_q == 3'd7) state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/polar_circle_point_generator_core.sv
// top level of the polar circle point generator
// channel | valid   | stall   | payload
// input   | valid_i | stall_o | req_type_i radius_i center_x_i center_y_i
// output  | valid_o | stall_i | point_x_o point_y_o octant_o last_of_step_o circle_done_o
//         |         |         | bad_radius_o
// a nonzero-radius start holds the input through acceptance, the bit-serial divider and the send state
// in the back a step is taken, rotated by CordicSteps cordic iterations, then sent as 8 output loads
// a step's first point follows the front send state, the queue, the back take and the cordic
// reset clears all control state and the held circle; no clearing pass
// output stalls fill the two-entry queue and then stall the input
module polar_circle_point_generator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               req_type_i,
  input  logic [15:0]        radius_i,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [17:0] point_x_o,
  output logic signed [17:0] point_y_o,
  output logic [2:0]         octant_o,
  output logic               last_of_step_o,
  output logic               circle_done_o,
  output logic               bad_radius_o
);
  import pcpg_pkg::*;

  logic f_valid, f_stall, b_valid, b_stall;
  cmd_t f_cmd, b_cmd;

  pcpg_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .req_type_i, .radius_i,
    .center_x_i, .center_y_i,
    .cmd_valid_o(f_valid), .cmd_stall_i(f_stall), .cmd_o(f_cmd)
  );

  pcpg_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_stall_o(f_stall), .in_cmd_i(f_cmd),
    .out_valid_o(b_valid), .out_stall_i(b_stall), .out_cmd_o(b_cmd)
  );

  pcpg_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_valid), .cmd_stall_o(b_stall), .cmd_i(b_cmd),
    .valid_o, .stall_i, .point_x_o, .point_y_o, .octant_o,
    .last_of_step_o, .circle_done_o, .bad_radius_o
  );

`ifndef NO_ASSERTIONS
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && circle_done_o |-> last_of_step_o) else $error("done without last");
  a_bad_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && bad_radius_o |-> !last_of_step_o && octant_o == 3'd0)
    else $error("bad radius result carries point data");
  a_last_oct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_of_step_o |-> octant_o == 3'd7) else $error("last not octant 7");
`endif

endmodule

// File: bench/polar_circle_point_generator_core_test.sv
// testbench for the polar circle point generator: directed and random circles against a predictor
module polar_circle_point_generator_core_test;
  import pcpg_pkg::*;

  typedef struct packed {
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic [2:0]         oct;
    logic               last;
    logic               done;
    logic               bad;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic req_type_i = 1'b0;
  logic [15:0] radius_i = '0;
  logic signed [15:0] center_x_i = '0;
  logic signed [15:0] center_y_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic signed [17:0] point_x_o, point_y_o;
  logic [2:0] octant_o;
  logic last_of_step_o, circle_done_o, bad_radius_o;

  polar_circle_point_generator_core uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic        circ_active;
  logic [23:0] circ_angle, circ_inc;
  logic [15:0] circ_radius;
  logic signed [15:0] circ_cx, circ_cy;
  point_t expected_points[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  localparam longint AtanTab[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  task automatic push_reflections(input longint x, input longint y, input logic fin);
    longint ox[8], oy[8];
    point_t p;
    ox = '{x, -x, -x, x, y, -y, -y, y};
    oy = '{y, y, -y, -y, x, x, -x, -x};
    for (int k = 0; k < 8; k++) begin
      p.px = 18'(longint'(circ_cx) + ox[k]);
      p.py = 18'(longint'(circ_cy) + oy[k]);
      p.oct = 3'(k);
      p.last = (k == 7);
      p.done = (k == 7) && fin;
      p.bad = 1'b0;
      expected_points.push_back(p);
    end
  endtask

  task automatic predict_points(input logic rt, input logic [15:0] r,
                                input logic signed [15:0] cx, input logic signed [15:0] cy);
    longint x, y, z, dx, dy, q, na;
    point_t p;
    if (rt == REQ_START) begin
      if (r == 0) begin
        circ_active = 1'b0;
        p = '0;
        p.bad = 1'b1;
        expected_points.push_back(p);
      end else begin
        circ_radius = r; circ_cx = cx; circ_cy = cy;
        q = (longint'(1) << 24) / r;
        circ_inc = (q > 24'hFFFFFF) ? 24'hFFFFFF : 24'(q);
        circ_angle = '0;
        circ_active = 1'b1;
        push_reflections(r, 0, 1'b0);
      end
    end else if (!circ_active || circ_angle >= AngleFinal) begin
      circ_active = 1'b0;
    end else begin
      x = (longint'(circ_radius) * 652032874) >>> 16;
      y = 0;
      z = longint'(circ_angle) << 14;
      for (int i = 0; i < CordicSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= AtanTab[i];
        end else begin
          x += dx; y -= dy; z += AtanTab[i];
        end
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      na = longint'(circ_angle) + circ_inc;
      circ_angle = (na > 24'hFFFFFF) ? 24'hFFFFFF : 24'(na);
      if (circ_angle >= AngleFinal) circ_active = 1'b0;
      push_reflections(x, y, circ_angle >= AngleFinal);
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // send one item; predicts at the accepting edge
  task automatic send_request(input logic rt, input logic [15:0] r,
                              input logic signed [15:0] cx, input logic signed [15:0] cy);
    valid_i <= 1'b1;
    req_type_i <= rt; radius_i <= r; center_x_i <= cx; center_y_i <= cy;
    do @(posedge clk_i); while (stall_o);
    predict_points(rt, r, cx, cy);
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    valid_i <= 1'b0;
    req_type_i <= 1'($urandom); radius_i <= 16'($urandom); center_x_i <= 16'($urandom);
    center_y_i <= 16'($urandom);
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 3) == 0) begin
      drop_valid();
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    drop_valid();
    while (expected_points.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic run_circle(input logic [15:0] r, input logic signed [15:0] cx,
                            input logic signed [15:0] cy, input int steps);
    send_request(REQ_START, r, cx, cy);
    for (int i = 0; i < steps; i++) begin
      idle_gap();
      send_request(REQ_STEP, 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_directed();
    send_request(REQ_STEP, 16'h0, 16'sh0, 16'sh0);           // step while idle
    send_request(REQ_START, 16'h0, 16'sh7FFF, -16'sh8000);   // zero radius
    run_circle(16'd1, 16'sh7FFF, 16'sh7FFF, 3);               // increment saturates
    run_circle(16'hFFFF, -16'sh8000, -16'sh8000, 4);
    run_circle(16'h0100, 16'sh0, 16'sh0, 2);
    send_request(REQ_START, 16'h0, 16'sh0, 16'sh0);          // abandons circle
    send_request(REQ_STEP, 16'h1234, 16'sh0, 16'sh0);
    wait_drained();
  endtask

  // radii up to 1200 finish within a few steps, so those circles run to the end; others get up to five steps
  task automatic test_random();
    int sent = 0;
    int n;
    logic [15:0] r;
    while (sent < 190) begin
      case ($urandom_range(0, 9))
        0: r = 16'd0;
        1, 2, 3: r = 16'($urandom_range(1, 120));
        4: r = 16'($urandom_range(1, 16'hFFFF));
        default: r = 16'($urandom_range(120, 1200));
      endcase
      n = (r != 0 && r <= 1200) ? (51470 / ((1 << 24) / r)) + $urandom_range(1, 3)
                                : $urandom_range(0, 5);
      if (n > 20) n = 20;
      run_circle(r, 16'($urandom), 16'($urandom), n);
      sent += n + 1;
      if ($urandom_range(0, 7) == 0) begin
        drop_valid();
        repeat ($urandom_range(5, 30)) @(negedge clk_i);
      end
    end
    wait_drained();
  endtask

  // receiver stall pattern: phases of none, light and heavy stalling
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: stall_i <= 1'b0;
      1: stall_i <= ($urandom_range(0, 3) == 0);
      default: stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    point_t exp_pt;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_points.size() == 0) begin
        report_mismatch("point with nothing expected");
      end else begin
        exp_pt = expected_points.pop_front();
        if (point_x_o !== exp_pt.px)
          report_mismatch($sformatf("point_x %0d exp %0d", point_x_o, exp_pt.px));
        if (point_y_o !== exp_pt.py)
          report_mismatch($sformatf("point_y %0d exp %0d", point_y_o, exp_pt.py));
        if (octant_o !== exp_pt.oct)
          report_mismatch($sformatf("octant %0d exp %0d", octant_o, exp_pt.oct));
        if (last_of_step_o !== exp_pt.last) report_mismatch("last_of_step");
        if (circle_done_o !== exp_pt.done) report_mismatch("circle_done");
        if (bad_radius_o !== exp_pt.bad) report_mismatch("bad_radius");
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    circ_active = 1'b0; circ_angle = '0; circ_inc = '0;
    circ_radius = '0; circ_cx = '0; circ_cy = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/pcpg_pkg.sv
hdl/pcpg_front.sv
hdl/pcpg_queue.sv
hdl/pcpg_back.sv
hdl/polar_circle_point_generator_core.sv
bench/polar_circle_point_generator_core_test.sv
